// ----- rtl/hsl_pkg.sv -----
package hsl_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 12;
   localparam int HUE_FULL     = 3600;

   // restoring divider: one quotient bit per stage, enough bits for hue and saturation
   localparam int DIV_STAGES = (CHANNEL_BITS > HUE_BITS) ? CHANNEL_BITS : HUE_BITS;
   localparam int DIV_BITS   = CHANNEL_BITS + 1;
   localparam int NUM_BITS   = DIV_BITS + DIV_STAGES;
   localparam int T_BITS     = CHANNEL_BITS + 14;
   localparam int LATENCY    = DIV_STAGES + 3;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef logic [CHANNEL_BITS-1:0] chan_type;

   typedef struct packed {
      logic [DIV_BITS-1:0]   rem;
      logic [DIV_STAGES-1:0] low;
      logic [DIV_BITS-1:0]   div;
   } div_type;

   typedef struct packed {
      div_type  hue;
      div_type  sat;
      logic     gray;
      chan_type lum;
      chan_type alpha;
   } pipe_type;

endpackage

// ----- rtl/hsl_front.sv -----
module hsl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hsl_pkg::chan_type  red,
   input  hsl_pkg::chan_type  green,
   input  hsl_pkg::chan_type  blue,
   input  hsl_pkg::chan_type  alpha,
   output logic               out_valid,
   input  logic               out_ready,
   output hsl_pkg::pipe_type  out_data
);

   localparam int CB = hsl_pkg::CHANNEL_BITS;
   localparam int TB = hsl_pkg::T_BITS;
   localparam int NB = hsl_pkg::NUM_BITS;
   localparam int DB = hsl_pkg::DIV_BITS;
   localparam int QB = hsl_pkg::DIV_STAGES;

   // stage A: max, min, sector
   logic              a_valid_ff;
   hsl_pkg::chan_type a_red_ff, a_green_ff, a_blue_ff, a_alpha_ff;
   hsl_pkg::chan_type a_max_ff, a_min_ff;
   logic [1:0]        a_sector_ff;
   hsl_pkg::chan_type max_in, min_in;
   logic [1:0]        sector_in;
   logic              a_ready;

   // stage B: hue and saturation numerators and divisors
   logic              b_valid_ff;
   hsl_pkg::pipe_type b_data_ff;
   hsl_pkg::pipe_type b_data_in;
   logic              b_ready;

   always_comb begin
      if (red > green) begin
         if (red > blue) begin
            max_in    = red;
            sector_in = hsl_pkg::SECTOR_RED;
         end else begin
            max_in    = blue;
            sector_in = hsl_pkg::SECTOR_BLUE;
         end
      end else if (blue > green) begin
         max_in    = blue;
         sector_in = hsl_pkg::SECTOR_BLUE;
      end else begin
         max_in    = green;
         sector_in = hsl_pkg::SECTOR_GREEN;
      end
      min_in = red;
      if (green < min_in) begin
         min_in = green;
      end
      if (blue < min_in) begin
         min_in = blue;
      end
   end

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready) begin
         a_red_ff    <= red;
         a_green_ff  <= green;
         a_blue_ff   <= blue;
         a_alpha_ff  <= alpha;
         a_max_ff    <= max_in;
         a_min_ff    <= min_in;
         a_sector_ff <= sector_in;
      end
   end

   hsl_pkg::chan_type       diff;
   logic [CB:0]             sum;
   logic [DB-1:0]           two_fs;
   logic [DB-1:0]           den;
   logic [2*CB-1:0]         sat_prod;
   logic signed [TB-1:0]    r_s, g_s, b_s, d_s, t;
   logic [NB-1:0]           hue_num, sat_num;

   always_comb begin
      diff   = a_max_ff - a_min_ff;
      sum    = {1'b0, a_max_ff} + {1'b0, a_min_ff};
      two_fs = {{CB{1'b1}}, 1'b0};
      den    = (sum > {1'b0, {CB{1'b1}}}) ? (two_fs - sum) : sum;
      sat_prod = {diff, {CB{1'b0}}} - {{CB{1'b0}}, diff};
      r_s = {{(TB-CB){1'b0}}, a_red_ff};
      g_s = {{(TB-CB){1'b0}}, a_green_ff};
      b_s = {{(TB-CB){1'b0}}, a_blue_ff};
      d_s = {{(TB-CB){1'b0}}, diff};
      case (a_sector_ff)
         hsl_pkg::SECTOR_RED: begin
            t = TB'(600 * (g_s - b_s));
            if (t < 0) begin
               t = TB'(t + 3600 * d_s);
            end
         end
         hsl_pkg::SECTOR_GREEN: begin
            t = TB'(1200 * d_s + 600 * (b_s - r_s));
         end
         hsl_pkg::SECTOR_BLUE: begin
            t = TB'(2400 * d_s + 600 * (r_s - g_s));
         end
         default: begin
            t = '0;
         end
      endcase
      hue_num = NB'(2 * t + d_s);
      sat_num = NB'(sat_prod);

      b_data_in.hue.rem = hue_num[NB-1:QB];
      b_data_in.hue.low = hue_num[QB-1:0];
      b_data_in.hue.div = {diff, 1'b0};
      b_data_in.sat.rem = sat_num[NB-1:QB];
      b_data_in.sat.low = sat_num[QB-1:0];
      b_data_in.sat.div = den;
      b_data_in.gray    = (diff == '0);
      b_data_in.lum     = sum[CB:1];
      b_data_in.alpha   = a_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ----- rtl/hsl_div_stage.sv -----
module hsl_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hsl_pkg::pipe_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hsl_pkg::pipe_type  out_data
);

   localparam int DB = hsl_pkg::DIV_BITS;
   localparam int QB = hsl_pkg::DIV_STAGES;

   logic              valid_ff;
   hsl_pkg::pipe_type data_ff;
   hsl_pkg::pipe_type data_in;

   // one restoring step: shift in the next numerator bit, subtract if it fits
   function automatic hsl_pkg::div_type div_step(input hsl_pkg::div_type v);
      hsl_pkg::div_type r;
      logic [DB:0]      x;
      logic [DB:0]      diff;
      logic             fits;
      x    = {v.rem, v.low[QB-1]};
      diff = x - {1'b0, v.div};
      fits = (x >= {1'b0, v.div});
      r.div = v.div;
      r.rem = fits ? diff[DB-1:0] : x[DB-1:0];
      r.low = {v.low[QB-2:0], fits};
      return r;
   endfunction

   always_comb begin
      data_in     = in_data;
      data_in.hue = div_step(in_data.hue);
      data_in.sat = div_step(in_data.sat);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/hsl_back.sv -----
module hsl_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hsl_pkg::pipe_type             in_data,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [hsl_pkg::HUE_BITS-1:0]  hue,
   output hsl_pkg::chan_type             saturation,
   output hsl_pkg::chan_type             luminance,
   output hsl_pkg::chan_type             alpha
);

   localparam int HB = hsl_pkg::HUE_BITS;
   localparam int CB = hsl_pkg::CHANNEL_BITS;

   logic              valid_ff;
   logic [HB-1:0]     hue_ff, hue_in, hue_q;
   hsl_pkg::chan_type sat_ff, sat_in, lum_ff, alpha_ff;

   always_comb begin
      hue_q = in_data.hue.low[HB-1:0];
      if (hue_q >= HB'(hsl_pkg::HUE_FULL)) begin
         hue_in = hue_q - HB'(hsl_pkg::HUE_FULL);
      end else begin
         hue_in = hue_q;
      end
      sat_in = in_data.sat.low[CB-1:0];
      if (in_data.gray) begin
         hue_in = '0;
         sat_in = '0;
      end
   end

   assign in_ready = !valid_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         lum_ff   <= in_data.lum;
         alpha_ff <= in_data.alpha;
      end
   end

   assign out_valid  = valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign luminance  = lum_ff;
   assign alpha      = alpha_ff;

endmodule

// ----- rtl/rgb_to_hsl_converter.sv -----
// Pipeline: from request accept to rsp_valid, two front stages, one stage per
//   quotient bit of the 12-bit restoring divider, one output register.
// Throughput: one request per cycle; each stage stalls only when it holds data that
//   the next stage cannot take, so bubbles are squeezed out under backpressure.
// Reset: synchronous, active high; clears all valid bits, data registers are not reset.
module rgb_to_hsl_converter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hsl_pkg::chan_type             req_red_in,
   input  hsl_pkg::chan_type             req_green_in,
   input  hsl_pkg::chan_type             req_blue_in,
   input  hsl_pkg::chan_type             req_alpha_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hsl_pkg::HUE_BITS-1:0]  rsp_hue_out,
   output hsl_pkg::chan_type             rsp_saturation_out,
   output hsl_pkg::chan_type             rsp_luminance_out,
   output hsl_pkg::chan_type             rsp_alpha_out
);

   localparam int NS = hsl_pkg::DIV_STAGES;

   hsl_pkg::pipe_type stage_data  [NS+1];
   logic              stage_valid [NS+1];
   logic              stage_ready [NS+1];
   logic              front_ready;

   hsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .alpha     (req_alpha_in),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   assign req_stall = !front_ready;

   for (genvar g = 0; g < NS; g++) begin : g_div
      hsl_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   hsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid[NS]),
      .in_ready   (stage_ready[NS]),
      .in_data    (stage_data[NS]),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .hue        (rsp_hue_out),
      .saturation (rsp_saturation_out),
      .luminance  (rsp_luminance_out),
      .alpha      (rsp_alpha_out)
   );

endmodule

// ----- rtl/hsl_checker.sv -----
module hsl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input hsl_pkg::chan_type             req_red_in,
   input hsl_pkg::chan_type             req_green_in,
   input hsl_pkg::chan_type             req_blue_in,
   input hsl_pkg::chan_type             req_alpha_in,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [hsl_pkg::HUE_BITS-1:0]  rsp_hue_out,
   input hsl_pkg::chan_type             rsp_saturation_out,
   input hsl_pkg::chan_type             rsp_luminance_out,
   input hsl_pkg::chan_type             rsp_alpha_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue_out)
         && $stable(rsp_saturation_out) && $stable(rsp_luminance_out)
         && $stable(rsp_alpha_out))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   a_hue_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue_out < hsl_pkg::HUE_BITS'(hsl_pkg::HUE_FULL))
         && (rsp_hue_out == '0 || rsp_saturation_out != '0))
      else $error("hue out of range or colored pixel with zero saturation");

endmodule

bind rgb_to_hsl_converter hsl_checker u_hsl_checker (.*);

// ----- tb/tb_rgb_to_hsl_converter.sv -----
`timescale 1ns / 100ps

module tb_rgb_to_hsl_converter;

   localparam int CLOCK_HALF  = 5;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 600;
   localparam hsl_pkg::chan_type FS = '1;

   typedef struct packed {
      logic [hsl_pkg::HUE_BITS-1:0] hue;
      hsl_pkg::chan_type            sat;
      hsl_pkg::chan_type            lum;
      hsl_pkg::chan_type            alpha;
   } hsl_value_type;

   class hsl_scoreboard;
      hsl_value_type pending[$];
      int            mismatches;
      int            checked;

      function hsl_value_type rgb_to_hsl(hsl_pkg::chan_type r, hsl_pkg::chan_type g,
                                         hsl_pkg::chan_type b, hsl_pkg::chan_type a);
         int            fs, mx, mn, d, sum, t, hue, sat, den;
         logic [1:0]    sector;
         hsl_value_type v;
         fs = (1 << hsl_pkg::CHANNEL_BITS) - 1;
         if (r > g) begin
            if (r > b) begin
               mx = int'(r);
               sector = hsl_pkg::SECTOR_RED;
            end else begin
               mx = int'(b);
               sector = hsl_pkg::SECTOR_BLUE;
            end
         end else if (b > g) begin
            mx = int'(b);
            sector = hsl_pkg::SECTOR_BLUE;
         end else begin
            mx = int'(g);
            sector = hsl_pkg::SECTOR_GREEN;
         end
         mn = int'(r);
         if (int'(g) < mn) mn = int'(g);
         if (int'(b) < mn) mn = int'(b);
         d = mx - mn;
         sum = mx + mn;
         hue = 0;
         sat = 0;
         if (d != 0) begin
            case (sector)
               hsl_pkg::SECTOR_RED: begin
                  t = 600 * (int'(g) - int'(b));
                  if (t < 0) t += 3600 * d;
               end
               hsl_pkg::SECTOR_GREEN: t = 1200 * d + 600 * (int'(b) - int'(r));
               default:               t = 2400 * d + 600 * (int'(r) - int'(g));
            endcase
            hue = (2 * t + d) / (2 * d);
            if (hue >= hsl_pkg::HUE_FULL) hue -= hsl_pkg::HUE_FULL;
            den = (sum > fs) ? (2 * fs - sum) : sum;
            sat = (d * fs) / den;
            if (sat > fs) sat = fs;
         end
         v.hue   = hue[hsl_pkg::HUE_BITS-1:0];
         v.sat   = sat[hsl_pkg::CHANNEL_BITS-1:0];
         v.lum   = sum[hsl_pkg::CHANNEL_BITS:1];
         v.alpha = a;
         return v;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void note_pixel(hsl_pkg::chan_type r, hsl_pkg::chan_type g,
                               hsl_pkg::chan_type b, hsl_pkg::chan_type a);
         pending.push_back(rgb_to_hsl(r, g, b, a));
      endfunction

      function void check_result(hsl_value_type got);
         hsl_value_type want;
         checked++;
         if (pending.size() == 0) begin
            flag($sformatf("result h=%0d s=%0d l=%0d a=%0d with no request pending",
                           got.hue, got.sat, got.lum, got.alpha));
            return;
         end
         want = pending.pop_front();
         if (got.hue !== want.hue || got.sat !== want.sat ||
             got.lum !== want.lum || got.alpha !== want.alpha)
            flag($sformatf("expected h=%0d s=%0d l=%0d a=%0d, got h=%0d s=%0d l=%0d a=%0d",
                           want.hue, want.sat, want.lum, want.alpha,
                           got.hue, got.sat, got.lum, got.alpha));
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   hsl_pkg::chan_type            req_red_in = '0;
   hsl_pkg::chan_type            req_green_in = '0;
   hsl_pkg::chan_type            req_blue_in = '0;
   hsl_pkg::chan_type            req_alpha_in = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [hsl_pkg::HUE_BITS-1:0] rsp_hue_out;
   hsl_pkg::chan_type            rsp_saturation_out;
   hsl_pkg::chan_type            rsp_luminance_out;
   hsl_pkg::chan_type            rsp_alpha_out;

   hsl_scoreboard board = new();
   int            send_idle_pct = 7;
   int            rcv_idle_pct = 76;
   int            sent = 0;
   int            directed = 0;
   int            idle_cycles = 0;

   rgb_to_hsl_converter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red_in         (req_red_in),
      .req_green_in       (req_green_in),
      .req_blue_in        (req_blue_in),
      .req_alpha_in       (req_alpha_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hue_out        (rsp_hue_out),
      .rsp_saturation_out (rsp_saturation_out),
      .rsp_luminance_out  (rsp_luminance_out),
      .rsp_alpha_out      (rsp_alpha_out)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      hsl_value_type got;
      logic          moved;
      moved = 1'b0;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.hue   = rsp_hue_out;
         got.sat   = rsp_saturation_out;
         got.lum   = rsp_luminance_out;
         got.alpha = rsp_alpha_out;
         board.check_result(got);
         moved = 1'b1;
      end
      if (!reset && req_valid && !req_stall) moved = 1'b1;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("tb_rgb_to_hsl_converter: FAIL");
         $finish;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   task automatic send_pixel(hsl_pkg::chan_type r, hsl_pkg::chan_type g,
                             hsl_pkg::chan_type b, hsl_pkg::chan_type a);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      req_alpha_in <= a;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pixel(r, g, b, a);
      sent++;
   endtask

   task automatic send_random_pixel();
      hsl_pkg::chan_type r, g, b, a;
      r = hsl_pkg::chan_type'($urandom);
      g = hsl_pkg::chan_type'($urandom);
      b = hsl_pkg::chan_type'($urandom);
      a = hsl_pkg::chan_type'($urandom);
      case ($urandom_range(9))
         0: begin
            g = r;
            b = r;
         end
         1: g = r;
         2: b = r;
         3: b = g;
         4: begin
            r = $urandom_range(1) ? FS : '0;
            g = $urandom_range(1) ? FS : '0;
            b = $urandom_range(1) ? FS : '0;
         end
         5: begin
            g = r + hsl_pkg::chan_type'($urandom_range(3));
            b = r - hsl_pkg::chan_type'($urandom_range(3));
         end
         default: ;
      endcase
      send_pixel(r, g, b, a);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(int snd_pct, int rcv_pct);
      send_idle_pct = snd_pct;
      rcv_idle_pct  = rcv_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // hold off until the pipe is empty, then restart from cold
         if (i == PHASE_ITEMS / 2) drain();
         send_random_pixel();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_pixel('0, '0, '0, '0);
      send_pixel(FS, FS, FS, FS);
      send_pixel(8'd128, 8'd128, 8'd128, 8'h55);
      send_pixel(FS, '0, '0, 8'hAA);
      send_pixel('0, FS, '0, 8'h01);
      send_pixel('0, '0, FS, 8'h80);
      send_pixel(FS, FS, '0, 8'h7F);
      send_pixel(FS, '0, FS, 8'hFE);
      send_pixel('0, FS, FS, 8'h33);
      send_pixel(8'd200, 8'd10, 8'd90, 8'hCC);
      send_pixel(8'd200, 8'd50, 8'd50, 8'h0F);
      send_pixel(8'd1, 8'd0, 8'd0, 8'hF0);
      send_pixel(8'd255, 8'd254, 8'd254, 8'h12);
      send_pixel(8'd0, 8'd1, 8'd1, 8'h34);
      send_pixel(8'd254, 8'd255, 8'd0, 8'h56);
      send_pixel(8'd7, 8'd3, 8'd0, 8'h78);
      send_pixel(8'd100, 8'd100, 8'd30, 8'h9A);
      send_pixel(8'd60, 8'd30, 8'd60, 8'hBC);
      send_pixel(8'd10, 8'd240, 8'd240, 8'hDE);
      send_pixel(8'd3, 8'd5, 8'd4, 8'hED);
      send_pixel(8'd128, 8'd127, 8'd0, 8'h00);
      send_pixel(8'd127, 8'd128, 8'd255, 8'hFF);
      directed = sent;

      run_phase(7, 76);
      run_phase(76, 7);
      run_phase(0, 0);

      drain();
      repeat (2 * hsl_pkg::LATENCY + 5) @(posedge clock);

      $display("sent %0d requests (%0d directed), checked %0d results", sent, directed,
               board.checked);
      $display("idle mixes: sender-light/receiver-heavy, the reverse, and none; %0d mismatches",
               board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("tb_rgb_to_hsl_converter: PASS");
      end else begin
         $display("tb_rgb_to_hsl_converter: FAIL");
      end
      $finish;
   end

endmodule
